### hw/rtl/vmsf_pkg.sv
// ----------------------------------------------------------------------------
// vmsf_pkg: shared types and constants
// Request layouts, configuration register map and mode encodings for the
// drive-mode safety supervisor.
// ----------------------------------------------------------------------------
package vmsf_pkg;

  localparam int TimeBits = 32;
  localparam int CfgBits  = 16;

  localparam logic [CfgBits-1:0] BootDelayReset = 16'd2000;
  localparam logic [CfgBits-1:0] HoldTimeReset  = 16'd1000;

  // configuration register indexes
  localparam logic CFG_BOOT_DELAY = 1'b0;
  localparam logic CFG_HOLD_TIME  = 1'b1;

  // host mode request codes
  localparam logic [1:0] CMD_MANUAL = 2'd0;
  localparam logic [1:0] CMD_AUTO   = 2'd1;

  // external mode codes
  localparam logic [2:0] CODE_INIT   = 3'd0;
  localparam logic [2:0] CODE_IDLE   = 3'd1;
  localparam logic [2:0] CODE_MANUAL = 3'd2;
  localparam logic [2:0] CODE_AUTO   = 3'd3;
  localparam logic [2:0] CODE_FAULT  = 3'd4;
  localparam logic [2:0] CODE_ESTOP  = 3'd5;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_MANUAL = 6'b000100,
    ST_AUTO   = 6'b001000,
    ST_FAULT  = 6'b010000,
    ST_ESTOP  = 6'b100000
  } mode_state_t;

  typedef struct packed {
    logic [TimeBits-1:0] now_ms;
    logic                fault_any;
    logic                heartbeat_ok;
    logic                deadman_held;
    logic [1:0]          commanded_mode;
    logic                reverse_on;
    logic                brake_on;
    logic                pedal_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          mode_code;
    logic                is_autonomous;
    logic                is_driving;
    logic [TimeBits-1:0] hold_start_ms;
    logic                mode_changed;
  } out_item_t;

  typedef struct packed {
    logic [CfgBits-1:0] boot_delay_ms;
    logic [CfgBits-1:0] hold_time_ms;
  } cfg_t;

  // one-hot state to external code
  function automatic logic [2:0] mode_to_code(mode_state_t st);
    logic [2:0] code;
    case (st)
      ST_INIT:   code = CODE_INIT;
      ST_IDLE:   code = CODE_IDLE;
      ST_MANUAL: code = CODE_MANUAL;
      ST_AUTO:   code = CODE_AUTO;
      ST_FAULT:  code = CODE_FAULT;
      ST_ESTOP:  code = CODE_ESTOP;
      default:   code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/vmsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// vmsf_cfg_regs: configuration registers
// Boot delay and dead-man hold time, written through a plain write port.
// ----------------------------------------------------------------------------
module vmsf_cfg_regs
  import vmsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CfgBits-1:0] cfg_data,
  output cfg_t               cfg
);

  cfg_t regs;

  // register writes, reset to the power-on timings
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.boot_delay_ms <= BootDelayReset;
      regs.hold_time_ms  <= HoldTimeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOOT_DELAY: regs.boot_delay_ms <= cfg_data;
        CFG_HOLD_TIME:  regs.hold_time_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/vmsf_mode_core.sv
// ----------------------------------------------------------------------------
// vmsf_mode_core: mode state machine
// Holds the mode and dead-man hold start, works out the next mode for one
// request and builds its result.
// ----------------------------------------------------------------------------
module vmsf_mode_core
  import vmsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  mode_state_t         mode;
  mode_state_t         mode_next;
  mode_state_t         forced;
  logic [TimeBits-1:0] hold_start;
  logic [TimeBits-1:0] hold_start_next;
  logic [TimeBits-1:0] hold_base;
  logic [TimeBits-1:0] hold_elapsed;
  logic                arm_ok;
  logic                leave_auto;

  // fault override comes first, then the normal transitions
  always_comb begin
    forced = mode;
    if (item.fault_any || (!item.heartbeat_ok && mode == ST_AUTO)) begin
      forced = ST_FAULT;
    end
  end

  assign arm_ok       = item.deadman_held && (item.commanded_mode == CMD_AUTO)
                        && !item.reverse_on;
  assign hold_base    = (hold_start == '0) ? item.now_ms : hold_start;
  assign hold_elapsed = item.now_ms - hold_base;
  assign leave_auto   = item.brake_on || item.pedal_on || !item.deadman_held
                        || (item.commanded_mode == CMD_MANUAL);

  always_comb begin
    mode_next       = forced;
    hold_start_next = hold_start;
    case (forced)
      ST_INIT: begin
        if (item.now_ms > TimeBits'(cfg.boot_delay_ms)) mode_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item.heartbeat_ok) mode_next = ST_MANUAL;
      end
      ST_MANUAL: begin
        if (arm_ok) begin
          hold_start_next = hold_base;
          if (hold_elapsed > TimeBits'(cfg.hold_time_ms)) mode_next = ST_AUTO;
        end else begin
          hold_start_next = '0;
        end
      end
      ST_AUTO: begin
        if (leave_auto) mode_next = ST_MANUAL;
      end
      ST_FAULT: begin
        if (item.heartbeat_ok && !item.deadman_held) mode_next = ST_IDLE;
      end
      default: ;
    endcase
  end

  // state update on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ST_INIT;
      hold_start <= '0;
    end else if (step) begin
      mode       <= mode_next;
      hold_start <= hold_start_next;
    end
  end

  // result for this request
  always_comb begin
    res.mode_code     = mode_to_code(mode_next);
    res.is_autonomous = (mode_next == ST_AUTO);
    res.is_driving    = (mode_next == ST_AUTO) || (mode_next == ST_MANUAL);
    res.hold_start_ms = hold_start_next;
    res.mode_changed  = (mode_next != mode);
  end

`ifndef SYNTHESIS
  // mode register always one-hot
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(mode))
    else $error("mode register not one-hot");

  // hold start only moves while in manual
  a_hold_only_manual: assert property (@(posedge clk) disable iff (rst)
    (step && forced != ST_MANUAL) |=> $stable(hold_start))
    else $error("hold start changed outside manual");

  // estop is never entered
  a_no_estop: assert property (@(posedge clk) disable iff (rst) mode != ST_ESTOP)
    else $error("estop entered");
`endif

endmodule

### hw/rtl/vehicle_mode_safety_fsm.sv
// ----------------------------------------------------------------------------
// vehicle_mode_safety_fsm: drive-mode safety supervisor, top level
// Datapath: input register, then result register after the mode logic.
// Throughput: one request per cycle; the input stage advances whenever the
// result register is empty or being taken.
// Reset: synchronous, active high; mode to init, hold start to zero, timings
// to 2000 ms boot delay and 1000 ms hold time, both stages emptied.
// ----------------------------------------------------------------------------
module vehicle_mode_safety_fsm
  import vmsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CfgBits-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      advance;
  out_item_t res;
  out_item_t result;
  logic      result_valid;

  vmsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage handshake
  assign advance  = item_valid && (!result_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  vmsf_mode_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (out_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  assign out_valid = result_valid;
  assign out_data  = result;

`ifndef SYNTHESIS
  // flag bits agree with the reported mode
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_autonomous == (out_data.mode_code == CODE_AUTO)) &&
                  (out_data.is_driving == ((out_data.mode_code == CODE_AUTO) ||
                                           (out_data.mode_code == CODE_MANUAL))))
    else $error("result flags disagree with mode code");

  // a stalled result blocks a waiting input request
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

  // a stalled result is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result lost or changed");
`endif

endmodule
